// File: rtl/core/sfd_pkg.sv
// shared types and constants of the signed floored divider
package sfd_pkg;

   localparam int DATA_WIDTH = 32;
   // input register, one cell per quotient bit, output register
   localparam int LATENCY    = DATA_WIDTH + 2;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic        [DATA_WIDTH-1:0] mag_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // one operand pair on its way down the chain
   typedef struct packed {
      mag_type    rem;       // partial remainder
      mag_type    numq;      // numerator bits still to shift out, quotient bits shifted in
      mag_type    den_mag;   // divisor magnitude
      mag_type    num_raw;   // numerator as received
      mag_type    den_raw;   // denominator as received
      logic       num_neg;
      logic       den_neg;
      status_type status;
   } slice_type;

endpackage

// File: rtl/core/sfd_prep.sv
// input stage: operand magnitudes, signs and special case detection
module sfd_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  sfd_pkg::word_type  numerator,
   input  sfd_pkg::word_type  denominator,
   output logic               valid,
   output sfd_pkg::slice_type slice
);
   import sfd_pkg::*;

   localparam mag_type MIN_VALUE = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic      valid_ff;
   slice_type slice_ff, slice_in;
   mag_type   n_u, d_u;

   always_comb begin
      n_u = mag_type'(numerator);
      d_u = mag_type'(denominator);
      slice_in.num_raw = n_u;
      slice_in.den_raw = d_u;
      slice_in.num_neg = n_u[DATA_WIDTH-1];
      slice_in.den_neg = d_u[DATA_WIDTH-1];
      slice_in.numq    = n_u[DATA_WIDTH-1] ? (~n_u + 1'b1) : n_u;
      slice_in.den_mag = d_u[DATA_WIDTH-1] ? (~d_u + 1'b1) : d_u;
      slice_in.rem     = '0;
      if (d_u == '0) begin
         slice_in.status = STATUS_DIV_ZERO;
      end else if (n_u == MIN_VALUE && d_u == '1) begin
         slice_in.status = STATUS_OVERFLOW;
      end else begin
         slice_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= load;
      end
      slice_ff <= slice_in;
   end

   assign valid = valid_ff;
   assign slice = slice_ff;

endmodule

// File: rtl/core/sfd_cell.sv
// one restoring division step: shift in a numerator bit, trial subtract, keep a quotient bit
module sfd_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_up,
   input  sfd_pkg::slice_type slice_up,
   output logic               valid_dn,
   output sfd_pkg::slice_type slice_dn
);
   import sfd_pkg::*;

   logic                  valid_ff;
   slice_type             slice_ff, slice_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;

   always_comb begin
      trial    = {slice_up.rem, slice_up.numq[DATA_WIDTH-1]};
      diff     = trial - {1'b0, slice_up.den_mag};
      slice_in = slice_up;
      // top bit of the difference set means the trial went below zero
      if (diff[DATA_WIDTH]) begin
         slice_in.rem  = trial[DATA_WIDTH-1:0];
         slice_in.numq = {slice_up.numq[DATA_WIDTH-2:0], 1'b0};
      end else begin
         slice_in.rem  = diff[DATA_WIDTH-1:0];
         slice_in.numq = {slice_up.numq[DATA_WIDTH-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_up;
      end
      slice_ff <= slice_in;
   end

   assign valid_dn = valid_ff;
   assign slice_dn = slice_ff;

endmodule

// File: rtl/core/sfd_post.sv
// output stage: sign restore, floor correction and special case results
module sfd_post (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid,
   input  sfd_pkg::slice_type  slice,
   output logic                strobe,
   output sfd_pkg::word_type   quotient,
   output sfd_pkg::word_type   remainder,
   output sfd_pkg::status_type status
);
   import sfd_pkg::*;

   logic       strobe_ff;
   mag_type    quot_ff, quot_in;
   mag_type    rem_ff, rem_in;
   status_type status_ff;
   logic       den_neg_ff;
   logic       differ, fix;
   mag_type    mr_sel, d_sel, q_sel;

   always_comb begin
      differ = slice.num_neg ^ slice.den_neg;
      fix    = differ && (slice.rem != '0);
      // floored: quotient is ~mq when corrected, -mq when only signs differ
      q_sel   = differ ? ~slice.numq : slice.numq;
      quot_in = q_sel + mag_type'(differ && !fix);
      // remainder: +-mr, plus the raw denominator when corrected
      mr_sel  = slice.num_neg ? ~slice.rem : slice.rem;
      d_sel   = fix ? slice.den_raw : '0;
      rem_in  = d_sel + mr_sel + mag_type'(slice.num_neg);
      case (slice.status)
         STATUS_DIV_ZERO: begin
            quot_in = '0;
            rem_in  = slice.num_raw;
         end
         STATUS_OVERFLOW: begin
            quot_in = slice.num_raw;
            rem_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      status_ff  <= slice.status;
      den_neg_ff <= slice.den_neg;
   end

   assign strobe    = strobe_ff;
   assign quotient  = word_type'(quot_ff);
   assign remainder = word_type'(rem_ff);
   assign status    = status_ff;

   // a normal remainder carries the sign of the denominator
   assert property (@(posedge clock) disable iff (reset)
      strobe_ff && status_ff == STATUS_OK && rem_ff != '0
         |-> rem_ff[DATA_WIDTH-1] == den_neg_ff)
      else $error("remainder sign differs from denominator sign");

   // divide by zero gives a zero quotient
   assert property (@(posedge clock) disable iff (reset)
      strobe_ff && status_ff == STATUS_DIV_ZERO |-> quot_ff == '0)
      else $error("divide by zero with nonzero quotient");

endmodule

// File: rtl/core/signed_floored_divider.sv
// top level of the pipelined signed floored divider
//
// takes one operand pair in every cycle (busy never rises) and returns its
// floored quotient and remainder in order on a one-cycle rsp_strobe that
// the receiver cannot hold off. each pair passes through an input register,
// a chain of DATA_WIDTH division cells, each producing one quotient bit,
// and an output register. status 1 flags divide by zero (quotient 0,
// remainder equals the numerator), status 2 flags the most negative value
// divided by minus one (quotient wraps to the minimum, remainder 0). no
// state is kept between items
module signed_floored_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sfd_pkg::word_type   req_numerator,
   input  sfd_pkg::word_type   req_denominator,
   output logic                rsp_strobe,
   output sfd_pkg::word_type   rsp_quotient,
   output sfd_pkg::word_type   rsp_remainder,
   output sfd_pkg::status_type rsp_status
);
   import sfd_pkg::*;

   // chain links: index 0 is the input register, index DATA_WIDTH the last cell
   logic      link_valid [DATA_WIDTH+1];
   slice_type link_slice [DATA_WIDTH+1];
   logic      transfer;

   // fully pipelined, so a new pair is always welcome
   assign busy     = 1'b0;
   assign transfer = start && !busy;

   sfd_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .load        (transfer),
      .numerator   (req_numerator),
      .denominator (req_denominator),
      .valid       (link_valid[0]),
      .slice       (link_slice[0])
   );

   // one cell per quotient bit, msb first
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      sfd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .valid_up (link_valid[i]),
         .slice_up (link_slice[i]),
         .valid_dn (link_valid[i+1]),
         .slice_dn (link_slice[i+1])
      );
   end

   sfd_post u_post (
      .clock     (clock),
      .reset     (reset),
      .valid     (link_valid[DATA_WIDTH]),
      .slice     (link_slice[DATA_WIDTH]),
      .strobe    (rsp_strobe),
      .quotient  (rsp_quotient),
      .remainder (rsp_remainder),
      .status    (rsp_status)
   );

   // every transfer comes out after the fixed latency
   assert property (@(posedge clock) disable iff (reset)
      transfer |-> ##(LATENCY) rsp_strobe)
      else $error("result missing after pipeline latency");

   // no result appears without a transfer the fixed latency earlier
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !$past(reset, LATENCY) |-> $past(transfer, LATENCY))
      else $error("result without matching transfer");

endmodule
